>>> sv/slid_pkg.sv
// Shared constants and types for the sorted list insert/delete block.
package slid_pkg;

	// Field widths and default list depth
	localparam int DATA_W         = 32;
	localparam int STATUS_W       = 2;
	localparam int COUNT_OUT_W    = 5;
	localparam int DEF_LIST_DEPTH = 16;

	// Operation codes
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

endpackage

>>> sv/slid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> sv/sorted_list_insert_delete.sv
// Top level: ascending list of signed values held in a RAM, with insert and delete.
//
// Usage:
//   Drive operation and value and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy stays high while the item
//   walks the list. Exactly one result follows each item: done pulses for one
//   cycle with status and entry_count valid in that cycle.
// Walk: insert into a full list, delete from an empty list and insert into an
//   empty list are answered from the idle state without a walk.
//   insert: one RAM read and shifted write per entry moved one slot up.
//   delete: the whole list is read once, entries past the match are written
//   back one slot lower.
//   The single RAM read port takes one entry per cycle; a new item may be
//   taken in the cycle that done is high.
// Reset: arst_n clears the entry count and the sequencer; RAM contents are
//   left as they are and are never read above the count.
// The receiver cannot stall: a result is shown for one cycle only.
module sorted_list_insert_delete #(
	parameter int LIST_DEPTH = slid_pkg::DEF_LIST_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               operation,
	input  logic signed [slid_pkg::DATA_W-1:0] value,
	output logic                               done,
	output logic [slid_pkg::STATUS_W-1:0]      status,
	output logic [slid_pkg::COUNT_OUT_W-1:0]   entry_count
);
	import slid_pkg::*;

	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int ADDR_W = $clog2(LIST_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_INS  = 3'b010,
		S_DEL  = 3'b100
	} state_t;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          k_q, k_d;
	logic [CNT_W-1:0]          i_q, i_d;
	logic                      found_q, found_d;
	logic signed [DATA_W-1:0]  v_q, v_d;
	logic                      done_q, done_d;
	status_t                   status_q, status_d;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [DATA_W-1:0]         ram_wdata;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [DATA_W-1:0]         ram_rdata;
	logic signed [DATA_W-1:0]  rd_val;
	logic                      hit;
	logic                      accept;

	assign rd_val = $signed(ram_rdata);
	assign accept = start && (state_q == S_IDLE);
	assign hit    = !found_q && (rd_val == v_q);

	// Entry storage
	slid_ram #(
		.WIDTH (DATA_W),
		.DEPTH (LIST_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: insert walks down from the top shifting entries up,
	// delete walks up from slot zero shifting entries past the match down
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		k_d       = k_q;
		i_d       = i_q;
		found_d   = found_q;
		v_d       = v_q;
		done_d    = 1'b0;
		status_d  = status_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = v_q;
		ram_raddr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					v_d = value;
					if (op_t'(operation) == OP_INSERT) begin
						if (count_q == CNT_W'(LIST_DEPTH)) begin
							done_d   = 1'b1;
							status_d = ST_FULL;
						end else if (count_q == '0) begin
							ram_we    = 1'b1;
							ram_waddr = '0;
							ram_wdata = value;
							count_d   = count_q + CNT_W'(1);
							done_d    = 1'b1;
							status_d  = ST_DONE;
						end else begin
							ram_raddr = ADDR_W'(count_q - CNT_W'(1));
							k_d       = count_q;
							state_d   = S_INS;
						end
					end else begin
						if (count_q == '0) begin
							done_d   = 1'b1;
							status_d = ST_NOT_FOUND;
						end else begin
							ram_raddr = '0;
							i_d       = '0;
							found_d   = 1'b0;
							state_d   = S_DEL;
						end
					end
				end
			end

			S_INS: begin
				ram_we = 1'b1;
				if (k_q == '0) begin
					// every stored entry was shifted: new value goes to slot zero
					ram_waddr = '0;
					ram_wdata = v_q;
					count_d   = count_q + CNT_W'(1);
					done_d    = 1'b1;
					status_d  = ST_DONE;
					state_d   = S_IDLE;
				end else if (rd_val >= v_q) begin
					ram_waddr = k_q[ADDR_W-1:0];
					ram_wdata = ram_rdata;
					ram_raddr = ADDR_W'(k_q - CNT_W'(2));
					k_d       = k_q - CNT_W'(1);
				end else begin
					ram_waddr = k_q[ADDR_W-1:0];
					ram_wdata = v_q;
					count_d   = count_q + CNT_W'(1);
					done_d    = 1'b1;
					status_d  = ST_DONE;
					state_d   = S_IDLE;
				end
			end

			S_DEL: begin
				if (found_q) begin
					ram_we    = 1'b1;
					ram_waddr = ADDR_W'(i_q - CNT_W'(1));
					ram_wdata = ram_rdata;
				end
				if (i_q == count_q - CNT_W'(1)) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
					if (found_q || hit) begin
						count_d  = count_q - CNT_W'(1);
						status_d = ST_DONE;
					end else begin
						status_d = ST_NOT_FOUND;
					end
				end else begin
					ram_raddr = ADDR_W'(i_q + CNT_W'(1));
					i_d       = i_q + CNT_W'(1);
					found_d   = found_q || hit;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// Working and result payload registers
	always_ff @(posedge clk) begin
		k_q      <= k_d;
		i_q      <= i_d;
		found_q  <= found_d;
		v_q      <= v_d;
		status_q <= status_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = COUNT_OUT_W'(count_q);

`ifndef SYNTH
	// A result only appears once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// The count never runs past the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_DEPTH))
		else $error("entry count exceeds list depth");

	// An insert taken on a full list reports full at once
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_INSERT && count_q == CNT_W'(LIST_DEPTH))
		|=> (done && status == ST_FULL))
		else $error("insert into full list not flagged");

	// The count moves only together with a result
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> done)
		else $error("entry count changed without a result");
`endif

endmodule
